// ----- sv/mpe_pkg.sv -----
package mpe_pkg;

   localparam int COUNT_BITS   = 24;
   localparam int SQ_BITS      = 4;
   localparam int IN_BITS      = 64;
   localparam int MAG_OUT_BITS = 63;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [COUNT_BITS-1:0] MAX_ITER_RESET  = 24'd256;
   localparam logic [SQ_BITS-1:0]    SQUARINGS_RESET = 4'd1;

   typedef enum logic [0:0] {
      REG_MAX_ITER  = 1'b0,
      REG_SQUARINGS = 1'b1
   } reg_idx_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MSEL,
      OP_PP,
      OP_FIN,
      OP_UPDZ,
      OP_MAG,
      OP_ADDC,
      OP_SNAP
   } op_type;

   typedef enum logic [1:0] {
      SEL_II,
      SEL_RR,
      SEL_IR
   } sel_type;

   typedef struct packed {
      op_type     op;
      sel_type    sel;
      logic [1:0] pp;
   } cmd_type;

   typedef struct packed {
      logic escape;
      logic match;
   } status_type;

endpackage

// ----- sv/mandelbrot_power_escape_iteration.sv -----
// Each point runs n iterations of S squarings each; S is the effective squarings (1..15).
// An iteration that escapes skips the add-c and period-check steps.
// Each squaring takes three multiplies on one shared 32x32 multiplier plus an update.
// One point at a time; a new request is accepted in the cycle of the strobe.
// Reset is synchronous: it idles the controller and restores the register defaults.
// The result strobe lasts one cycle and the receiver cannot stall it.
module mandelbrot_power_escape_iteration #(
   parameter int WORD_BITS   = 64,
   parameter int PERIOD_SPAN = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [mpe_pkg::IN_BITS-1:0]   req_c_real,
   input  logic signed [mpe_pkg::IN_BITS-1:0]   req_c_imag,
   output logic                                 rsp_valid,
   output logic [mpe_pkg::COUNT_BITS-1:0]       rsp_remaining_count,
   output logic [mpe_pkg::MAG_OUT_BITS-1:0]     rsp_last_magnitude_sq,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [mpe_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [mpe_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [mpe_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                 pready
);
   import mpe_pkg::*;

   logic [COUNT_BITS-1:0] max_iterations;
   logic [SQ_BITS-1:0]    squarings;
   cmd_type               cmd;
   status_type            status;

   mpe_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .max_iterations (max_iterations),
      .squarings      (squarings)
   );

   mpe_ctrl #(
      .PERIOD_SPAN (PERIOD_SPAN)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .max_iterations      (max_iterations),
      .squarings           (squarings),
      .status              (status),
      .cmd                 (cmd),
      .rsp_valid           (rsp_valid),
      .rsp_remaining_count (rsp_remaining_count)
   );

   mpe_dpath #(
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .c_real            (req_c_real),
      .c_imag            (req_c_imag),
      .status            (status),
      .last_magnitude_sq (rsp_last_magnitude_sq)
   );

endmodule

// ----- sv/mpe_csr.sv -----
module mpe_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mpe_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [mpe_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [mpe_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready,
   output logic [mpe_pkg::COUNT_BITS-1:0]      max_iterations,
   output logic [mpe_pkg::SQ_BITS-1:0]         squarings
);
   import mpe_pkg::*;

   logic [COUNT_BITS-1:0] max_iter_ff;
   logic [SQ_BITS-1:0]    squarings_ff;
   reg_idx_type           index;

   // Registers sit on 4-byte boundaries, so bit 2 selects the register.
   assign index  = reg_idx_type'(paddr[2]);
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff  <= MAX_ITER_RESET;
         squarings_ff <= SQUARINGS_RESET;
      end else if (psel && penable && pwrite) begin
         case (index)
            REG_MAX_ITER:  max_iter_ff  <= pwdata[COUNT_BITS-1:0];
            REG_SQUARINGS: squarings_ff <= pwdata[SQ_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_MAX_ITER:  prdata = CSR_DATA_BITS'(max_iter_ff);
         REG_SQUARINGS: prdata = CSR_DATA_BITS'(squarings_ff);
         default:       prdata = '0;
      endcase
   end

   assign max_iterations = max_iter_ff;
   assign squarings      = squarings_ff;

endmodule

// ----- sv/mpe_dpath.sv -----
module mpe_dpath #(
   parameter int WORD_BITS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mpe_pkg::cmd_type                     cmd,
   input  logic signed [mpe_pkg::IN_BITS-1:0]   c_real,
   input  logic signed [mpe_pkg::IN_BITS-1:0]   c_imag,
   output mpe_pkg::status_type                  status,
   output logic [mpe_pkg::MAG_OUT_BITS-1:0]     last_magnitude_sq
);
   import mpe_pkg::*;

   localparam int W    = WORD_BITS;
   localparam int FRAC = W - 8;
   localparam int DROP = IN_BITS - W;
   localparam int HW   = (W + 1) / 2;
   localparam int PW   = 2 * HW;
   localparam int AW   = 4 * HW;

   localparam logic [W-1:0]   MINV   = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0]   MAXV   = ~MINV;
   localparam logic [W-2:0]   RADIUS = (W-1)'(1) << (W - 6);

   logic [W-1:0]  cr_ff, ci_ff, zr_ff, zi_ff, zr2_ff, zi2_ff, zir_ff, pzr_ff, pzi_ff;
   logic [W-1:0]  cr_in, ci_in, zr_in, zi_in, zr2_in, zi2_in, zir_in, pzr_in, pzi_in;
   logic [PW-1:0] ma_ff, mb_ff, ma_in, mb_in, prod_ff, prod_in;
   logic          neg_ff, neg_in, pp_valid_ff, pp_valid_in;
   logic [1:0]    pp_idx_ff, pp_idx_in;
   logic [AW-1:0] acc_ff, acc_in, term, q_full, lim_ext;
   logic [W-2:0]  dist_ff, dist_in;

   logic signed [IN_BITS-1:0] cr_shift, ci_shift;
   logic [W-1:0]  op_a, op_b, q, fin_res, mag_sum;
   logic [HW-1:0] a_half, b_half;

   function automatic logic [W-1:0] sat_word(input logic [W:0] s);
      if (s[W] != s[W-1]) begin
         return s[W] ? MINV : MAXV;
      end
      return s[W-1:0];
   endfunction

   function automatic logic [W-1:0] abs_word(input logic [W-1:0] v);
      return v[W-1] ? (~v + 1'b1) : v;
   endfunction

   assign cr_shift = c_real >>> DROP;
   assign ci_shift = c_imag >>> DROP;

   assign a_half = cmd.pp[1] ? ma_ff[PW-1:HW] : ma_ff[HW-1:0];
   assign b_half = cmd.pp[0] ? mb_ff[PW-1:HW] : mb_ff[HW-1:0];
   assign prod_in = PW'(a_half) * PW'(b_half);

   always_comb begin
      case (pp_idx_ff)
         2'd0:    term = AW'(prod_ff);
         2'd3:    term = AW'(prod_ff) << (2 * HW);
         default: term = AW'(prod_ff) << HW;
      endcase
   end

   // Truncate toward zero on the magnitude, saturate, then restore the sign.
   assign q_full  = acc_ff >> FRAC;
   assign lim_ext = AW'(neg_ff ? MINV : MAXV);
   assign q       = (q_full > lim_ext) ? lim_ext[W-1:0] : q_full[W-1:0];
   assign fin_res = neg_ff ? (~q + 1'b1) : q;

   assign mag_sum = zr2_ff + zi2_ff;

   always_comb begin
      op_a = zi_ff;
      op_b = zi_ff;
      case (cmd.sel)
         SEL_II: begin
            op_a = zi_ff;
            op_b = zi_ff;
         end
         SEL_RR: begin
            op_a = zr_ff;
            op_b = zr_ff;
         end
         SEL_IR: begin
            op_a = zi_ff;
            op_b = zr_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      cr_in       = cr_ff;
      ci_in       = ci_ff;
      zr_in       = zr_ff;
      zi_in       = zi_ff;
      zr2_in      = zr2_ff;
      zi2_in      = zi2_ff;
      zir_in      = zir_ff;
      pzr_in      = pzr_ff;
      pzi_in      = pzi_ff;
      ma_in       = ma_ff;
      mb_in       = mb_ff;
      neg_in      = neg_ff;
      dist_in     = dist_ff;
      pp_valid_in = 1'b0;
      pp_idx_in   = cmd.pp;
      acc_in      = acc_ff;

      // The partial product registered last cycle is folded in here.
      if (pp_valid_ff) begin
         acc_in = (pp_idx_ff == 2'd0) ? term : (acc_ff + term);
      end

      case (cmd.op)
         OP_LOAD: begin
            cr_in = cr_shift[W-1:0];
            ci_in = ci_shift[W-1:0];
            zr_in = cr_shift[W-1:0];
            zi_in = ci_shift[W-1:0];
         end
         OP_MSEL: begin
            ma_in  = PW'(abs_word(op_a));
            mb_in  = PW'(abs_word(op_b));
            neg_in = op_a[W-1] ^ op_b[W-1];
         end
         OP_PP: begin
            pp_valid_in = 1'b1;
         end
         OP_FIN: begin
            case (cmd.sel)
               SEL_II:  zi2_in = fin_res;
               SEL_RR:  zr2_in = fin_res;
               SEL_IR:  zir_in = fin_res;
               default: ;
            endcase
         end
         OP_UPDZ: begin
            zr_in = sat_word({zr2_ff[W-1], zr2_ff} - {zi2_ff[W-1], zi2_ff});
            zi_in = sat_word({zir_ff[W-1], zir_ff} + {zir_ff[W-1], zir_ff});
         end
         OP_MAG: begin
            dist_in = mag_sum[W-1] ? '1 : mag_sum[W-2:0];
         end
         OP_ADDC: begin
            zr_in = sat_word({zr_ff[W-1], zr_ff} + {cr_ff[W-1], cr_ff});
            zi_in = sat_word({zi_ff[W-1], zi_ff} + {ci_ff[W-1], ci_ff});
         end
         OP_SNAP: begin
            pzr_in = zr_ff;
            pzi_in = zi_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      cr_ff     <= cr_in;
      ci_ff     <= ci_in;
      zr_ff     <= zr_in;
      zi_ff     <= zi_in;
      zr2_ff    <= zr2_in;
      zi2_ff    <= zi2_in;
      zir_ff    <= zir_in;
      pzr_ff    <= pzr_in;
      pzi_ff    <= pzi_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      neg_ff    <= neg_in;
      prod_ff   <= prod_in;
      pp_idx_ff <= pp_idx_in;
      acc_ff    <= acc_in;
      dist_ff   <= dist_in;
      if (reset) begin
         pp_valid_ff <= 1'b0;
      end else begin
         pp_valid_ff <= pp_valid_in;
      end
   end

   assign status.escape     = dist_ff > RADIUS;
   assign status.match      = (zr_ff == pzr_ff) && (zi_ff == pzi_ff);
   assign last_magnitude_sq = MAG_OUT_BITS'(dist_ff) << DROP;

endmodule

// ----- sv/mpe_ctrl.sv -----
module mpe_ctrl #(
   parameter int PERIOD_SPAN = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [mpe_pkg::COUNT_BITS-1:0]   max_iterations,
   input  logic [mpe_pkg::SQ_BITS-1:0]      squarings,
   input  mpe_pkg::status_type              status,
   output mpe_pkg::cmd_type                 cmd,
   output logic                             rsp_valid,
   output logic [mpe_pkg::COUNT_BITS-1:0]   rsp_remaining_count
);
   import mpe_pkg::*;

   localparam int PHASE_BITS = $clog2(PERIOD_SPAN + 1);
   localparam logic [PHASE_BITS-1:0] PHASE_LAST = PHASE_BITS'(PERIOD_SPAN);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MSEL,
      S_PP,
      S_DRAIN,
      S_FIN,
      S_UPD,
      S_MAG,
      S_ESC,
      S_ADDC,
      S_PER
   } state_type;

   state_type             state_ff;
   sel_type               sel_ff;
   logic [1:0]            pp_ff;
   logic [SQ_BITS-1:0]    sq_cnt_ff, sq_total_ff;
   logic [COUNT_BITS-1:0] count_ff, rsp_count_ff;
   logic [PHASE_BITS-1:0] phase_ff;
   logic                  snap_valid_ff, rsp_valid_ff, periodic;

   assign busy     = (state_ff != S_IDLE);
   assign periodic = snap_valid_ff && status.match;

   always_comb begin
      cmd.op  = OP_NONE;
      cmd.sel = sel_ff;
      cmd.pp  = pp_ff;
      case (state_ff)
         S_IDLE:  if (start) cmd.op = OP_LOAD;
         S_MSEL:  cmd.op = OP_MSEL;
         S_PP:    cmd.op = OP_PP;
         S_FIN:   cmd.op = OP_FIN;
         S_UPD:   cmd.op = OP_UPDZ;
         S_MAG:   cmd.op = OP_MAG;
         S_ADDC:  cmd.op = OP_ADDC;
         S_PER:   if (!periodic && (phase_ff >= PHASE_LAST)) cmd.op = OP_SNAP;
         default: cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         sel_ff        <= SEL_II;
         pp_ff         <= '0;
         sq_cnt_ff     <= '0;
         sq_total_ff   <= SQUARINGS_RESET;
         count_ff      <= '0;
         rsp_count_ff  <= '0;
         phase_ff      <= '0;
         snap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  count_ff      <= (max_iterations == '0) ? COUNT_BITS'(1) : max_iterations;
                  sq_total_ff   <= (squarings == '0) ? SQ_BITS'(1) : squarings;
                  sq_cnt_ff     <= '0;
                  phase_ff      <= '0;
                  snap_valid_ff <= 1'b0;
                  sel_ff        <= SEL_II;
                  state_ff      <= S_MSEL;
               end
            end
            S_MSEL: begin
               pp_ff    <= '0;
               state_ff <= S_PP;
            end
            S_PP: begin
               pp_ff <= pp_ff + 2'd1;
               if (&pp_ff) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: state_ff <= S_FIN;
            S_FIN: begin
               case (sel_ff)
                  SEL_II: begin
                     sel_ff   <= SEL_RR;
                     state_ff <= S_MSEL;
                  end
                  SEL_RR: begin
                     sel_ff   <= SEL_IR;
                     state_ff <= S_MSEL;
                  end
                  default: state_ff <= S_UPD;
               endcase
            end
            S_UPD: begin
               sel_ff <= SEL_II;
               if (sq_cnt_ff == sq_total_ff - SQ_BITS'(1)) begin
                  sq_cnt_ff <= '0;
                  state_ff  <= S_MAG;
               end else begin
                  sq_cnt_ff <= sq_cnt_ff + SQ_BITS'(1);
                  state_ff  <= S_MSEL;
               end
            end
            S_MAG: state_ff <= S_ESC;
            S_ESC: begin
               if (status.escape) begin
                  rsp_count_ff <= count_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  state_ff <= S_ADDC;
               end
            end
            S_ADDC: state_ff <= S_PER;
            S_PER: begin
               if (periodic) begin
                  rsp_count_ff <= '0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  if (phase_ff >= PHASE_LAST) begin
                     snap_valid_ff <= 1'b1;
                     phase_ff      <= '0;
                  end else begin
                     phase_ff <= phase_ff + PHASE_BITS'(1);
                  end
                  if (count_ff == COUNT_BITS'(1)) begin
                     rsp_count_ff <= '0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     count_ff <= count_ff - COUNT_BITS'(1);
                     state_ff <= S_MSEL;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_remaining_count = rsp_count_ff;

   // A result only follows one of the two decision states.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_ESC || state_ff == S_PER))
      else $error("result strobe without a decision");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   assert property (@(posedge clock) disable iff (reset)
      busy |-> (count_ff != '0 && sq_cnt_ff < sq_total_ff))
      else $error("iteration counters out of range while busy");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && state_ff == S_MSEL && sel_ff == SEL_II))
      else $error("accepted request did not start the first multiply");

endmodule
